// ===== src/arn_pkg.sv =====
// Shared types and constants for the auto-range normalizer.
package arn_pkg;

  // Sample, range and quotient width
  localparam int DATA_W = 16;

  // Range restored by a range reset: -1..+1 volt in Q5.10
  localparam logic signed [DATA_W-1:0] RANGE_LOW_INIT  = -16'sd1024;
  localparam logic signed [DATA_W-1:0] RANGE_HIGH_INIT = 16'sd1024;

  // Quotient bits produced by the serial divider
  localparam int QUOT_STEPS = DATA_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIDEN,
    ST_PREP,
    ST_START,
    ST_DIV,
    ST_DONE
  } arn_state_t;

  // Controls from the sequencer to the range store
  typedef struct packed {
    logic widen;   // latch the widened range of the selected channel
    logic commit;  // write back the range and form numerator and divisor
    logic clear;   // restore the reset range instead of the widened one
  } range_ctl_t;

  // Status from the serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== src/arn_range.sv =====
// Per-channel running range store with widen and write-back steps.
module arn_range #(
  parameter int CHANNELS = 2,
  parameter int IDX_W    = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  arn_pkg::range_ctl_t               ctl,
  input  logic [IDX_W-1:0]                  idx,
  input  logic signed [arn_pkg::DATA_W-1:0] sample,
  output logic [arn_pkg::DATA_W-1:0]        num,
  output logic [arn_pkg::DATA_W-1:0]        den
);
  import arn_pkg::*;

  logic signed [DATA_W-1:0] lo_r [CHANNELS];
  logic signed [DATA_W-1:0] hi_r [CHANNELS];
  logic signed [DATA_W-1:0] lo_w_r, lo_w_nxt;
  logic signed [DATA_W-1:0] hi_w_r, hi_w_nxt;
  logic [DATA_W-1:0]        num_r, den_r;
  logic signed [DATA_W-1:0] cur_lo, cur_hi;

  // Widen the selected channel's range to include the sample
  always_comb begin
    cur_lo   = lo_r[idx];
    cur_hi   = hi_r[idx];
    lo_w_nxt = (sample < cur_lo) ? sample : cur_lo;
    hi_w_nxt = (sample > cur_hi) ? sample : cur_hi;
  end

  // Hold the widened range for the write-back step
  always_ff @(posedge clk) begin
    if (ctl.widen) begin
      lo_w_r <= lo_w_nxt;
      hi_w_r <= hi_w_nxt;
    end
  end

  // Write back the range, restoring it when the reset flag is set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        lo_r[i] <= RANGE_LOW_INIT;
        hi_r[i] <= RANGE_HIGH_INIT;
      end
    end else if (ctl.commit) begin
      lo_r[idx] <= ctl.clear ? RANGE_LOW_INIT : lo_w_r;
      hi_r[idx] <= ctl.clear ? RANGE_HIGH_INIT : hi_w_r;
    end
  end

  // Form numerator and divisor from the widened range; both are non-negative
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      num_r <= DATA_W'(sample - lo_w_r);
      den_r <= DATA_W'(hi_w_r - lo_w_r);
    end
  end

  assign num = num_r;
  assign den = den_r;

endmodule

// ===== src/arn_div_serial.sv =====
// Restoring divider producing one quotient bit per cycle of num*2^16/den.
module arn_div_serial (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [arn_pkg::DATA_W-1:0] num,
  input  logic [arn_pkg::DATA_W-1:0] den,
  output arn_pkg::div_status_t       status,
  output logic [arn_pkg::DATA_W-1:0] quot
);
  import arn_pkg::*;

  localparam int CNT_W = $clog2(QUOT_STEPS);

  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] den_r;
  logic              sat_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [DATA_W:0]   rem_dbl;
  logic              fits;

  // Shift the remainder and try to subtract the divisor
  always_comb begin
    rem_dbl = {rem_r, 1'b0};
    fits    = (rem_dbl >= {1'b0, den_r});
    rem_nxt = fits ? DATA_W'(rem_dbl - {1'b0, den_r}) : rem_dbl[DATA_W-1:0];
  end

  // Load operands on start, then advance one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      sat_r <= (num == den);
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[DATA_W-2:0], fits};
    end
  end

  // Count steps and flag the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUOT_STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Sample at the top of the range saturates to all ones
  assign quot        = sat_r ? '1 : q_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// ===== src/auto_range_normalizer_core.sv =====
// Top level of the auto-range normalizer: sequencer, output register, checks.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------------
//   in_     | input     | in_valid / in_stall   | in_channel, in_sample, in_range_reset
//   out_    | output    | out_valid / out_stall | out_channel_out, out_normalized
//
// An item passes these steps from transfer to result: widen the range,
// write it back and form the operands, load the divider, run the bit-serial
// divider (one quotient bit per cycle), see it finish, then load the output.
// The next transfer is taken only in the idle state after the output load,
// so no new item is accepted before the last one has been loaded.
// rst_n is synchronous, active low, and restores every channel to -1..+1 volt.
// A stalled result is held in the output register; the next item is taken
// as soon as the result is loaded, while that result still waits.
module auto_range_normalizer_core #(
  parameter int CHANNELS = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_channel,
  input  logic signed [arn_pkg::DATA_W-1:0] in_sample,
  input  logic                              in_range_reset,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_channel_out,
  output logic signed [arn_pkg::DATA_W-1:0] out_normalized
);
  import arn_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  arn_state_t               state_r, state_nxt;
  logic                     ch_r;
  logic [IDX_W-1:0]         idx_r;
  logic signed [DATA_W-1:0] sample_r;
  logic                     clear_r;
  logic                     out_valid_r;
  logic                     out_ch_r;
  logic signed [DATA_W-1:0] out_norm_r;

  range_ctl_t               range_ctl;
  logic                     div_start;
  div_status_t              div_stat;
  logic [DATA_W-1:0]        num, den, quot;
  logic                     in_xfer, out_xfer, out_load;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_WIDEN;
      ST_WIDEN: state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (div_stat.done) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    range_ctl.widen  = 1'b0;
    range_ctl.commit = 1'b0;
    range_ctl.clear  = clear_r;
    div_start        = 1'b0;
    out_load         = 1'b0;
    in_stall         = 1'b1;
    case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_WIDEN: range_ctl.widen = 1'b1;
      ST_PREP:  range_ctl.commit = 1'b1;
      ST_START: div_start = 1'b1;
      ST_DONE:  out_load = !out_valid_r || !out_stall;
      default:  in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ch_r     <= in_channel;
      idx_r    <= (CHANNELS > 1) ? IDX_W'(in_channel) : '0;
      sample_r <= in_sample;
      clear_r  <= in_range_reset;
    end
  end

  arn_range #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_range (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (range_ctl),
    .idx    (idx_r),
    .sample (sample_r),
    .num    (num),
    .den    (den)
  );

  arn_div_serial u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (num),
    .den    (den),
    .status (div_stat),
    .quot   (quot)
  );

  // Drop the result on transfer, load a new one when the register frees
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  // Offset the quotient by -32768: flip its top bit
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r   <= ch_r;
      out_norm_r <= {~quot[DATA_W-1], quot[DATA_W-2:0]};
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel_out = out_ch_r;
  assign out_normalized  = out_norm_r;

  // An accepted item always starts with the widen step
  a_accept_widen: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_WIDEN))
    else $error("accepted item did not enter widen step");

  // The divisor is at least two volts whenever a division starts
  a_den_span: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (den >= 16'd2048))
    else $error("divisor below two volts at divider start");

  // The divider works and finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.done || div_stat.busy) |-> (state_r == ST_DIV))
    else $error("divider active outside divide state");

  // A new result appears only from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result loaded outside done state");

endmodule

// ===== sim/auto_range_normalizer_core_tb.sv =====
// Self-checking testbench for the auto-range normalizer core.
`timescale 1ns / 100ps

// Tracks per-channel ranges and checks each normalized result in order
class normalizer_scoreboard;
  localparam int NUM_CH = 2;

  typedef struct {
    logic                              channel;
    logic signed [arn_pkg::DATA_W-1:0] normalized;
  } norm_result_t;

  logic signed [arn_pkg::DATA_W-1:0] range_lo[NUM_CH];
  logic signed [arn_pkg::DATA_W-1:0] range_hi[NUM_CH];
  norm_result_t                      expected_norm_q[$];
  int                                errors;

  function new();
    errors = 0;
    for (int i = 0; i < NUM_CH; i++) begin
      range_lo[i] = arn_pkg::RANGE_LOW_INIT;
      range_hi[i] = arn_pkg::RANGE_HIGH_INIT;
    end
  endfunction

  // Widen the range, rescale the sample, then apply a range reset if flagged
  function logic signed [arn_pkg::DATA_W-1:0] normalize_sample(
    int idx, logic signed [arn_pkg::DATA_W-1:0] sample, logic range_reset);
    int     s_i;
    int     lo_i;
    int     hi_i;
    longint quot;
    longint scaled;
    s_i  = sample;
    lo_i = range_lo[idx];
    hi_i = range_hi[idx];
    if (s_i < lo_i) lo_i = s_i;
    if (s_i > hi_i) hi_i = s_i;
    quot = (longint'(s_i - lo_i) * 65536) / longint'(hi_i - lo_i);
    // Saturate when the sample sits at the top of the range
    if (quot > 65535) quot = 65535;
    scaled = quot - 32768;
    if (range_reset) begin
      range_lo[idx] = arn_pkg::RANGE_LOW_INIT;
      range_hi[idx] = arn_pkg::RANGE_HIGH_INIT;
    end else begin
      range_lo[idx] = lo_i[arn_pkg::DATA_W-1:0];
      range_hi[idx] = hi_i[arn_pkg::DATA_W-1:0];
    end
    return scaled[arn_pkg::DATA_W-1:0];
  endfunction

  // Predict the result of an accepted input transfer
  function void note_input(logic channel, logic signed [arn_pkg::DATA_W-1:0] sample,
                           logic range_reset);
    norm_result_t r;
    r.channel    = channel;
    r.normalized = normalize_sample(int'(channel) % NUM_CH, sample, range_reset);
    expected_norm_q.push_back(r);
  endfunction

  // Compare an accepted result against the oldest prediction
  function void check_result(logic channel, logic signed [arn_pkg::DATA_W-1:0] normalized);
    norm_result_t r;
    if (expected_norm_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected result channel=%0d normalized=%0d",
                 $time, channel, normalized);
      return;
    end
    r = expected_norm_q.pop_front();
    if (channel !== r.channel || normalized !== r.normalized) begin
      errors++;
      if (errors <= 10)
        $display("%0t: mismatch: expected channel=%0d normalized=%0d, got channel=%0d normalized=%0d",
                 $time, r.channel, r.normalized, channel, normalized);
    end
  endfunction

  function int pending();
    return expected_norm_q.size();
  endfunction
endclass

module auto_range_normalizer_core_tb;
  import arn_pkg::*;

  localparam int RANDOM_ITEMS = 1530;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int SETTLE       = 40;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_channel;
  logic signed [DATA_W-1:0] in_sample;
  logic                     in_range_reset;
  logic                     out_valid;
  logic                     out_stall;
  logic                     out_channel_out;
  logic signed [DATA_W-1:0] out_normalized;

  normalizer_scoreboard sb;
  int                   items_accepted;
  int                   idle_cycles;

  auto_range_normalizer_core #(
    .CHANNELS(2)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_channel     (in_channel),
    .in_sample      (in_sample),
    .in_range_reset (in_range_reset),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel_out(out_channel_out),
    .out_normalized (out_normalized)
  );

  // 100 MHz clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Record transfers on both channels and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_input(in_channel, in_sample, in_range_reset);
        items_accepted++;
      end
      if (out_valid && !out_stall)
        sb.check_result(out_channel_out, out_normalized);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // Offer one sample and hold it until the transfer
  task automatic send_sample(input logic ch, input logic signed [DATA_W-1:0] sample,
                             input logic range_reset);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_channel     <= ch;
    in_sample      <= sample;
    in_range_reset <= range_reset;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid for a number of cycles, with junk on the payload
  task automatic idle_sender(input int cycles);
    @(negedge clk);
    in_valid       <= 1'b0;
    in_channel     <= 1'($urandom);
    in_sample      <= 16'($urandom);
    in_range_reset <= 1'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Receiver: change stall mode now and then, and hold off once for a long stretch
  initial begin : receiver
    int mode;
    int span;
    int phase;
    int period;
    bit long_done;
    out_stall = 1'b0;
    long_done = 1'b0;
    mode      = 0;
    span      = 0;
    phase     = 0;
    period    = 4;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!long_done && items_accepted >= 300) begin
        long_done = 1'b1;
        mode      = 4;
        span      = HOLD_CYCLES;
      end else if (span == 0) begin
        mode   = $urandom_range(0, 3);
        span   = $urandom_range(30, 300);
        period = $urandom_range(2, 16);
        phase  = 0;
      end
      span--;
      phase++;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 7) != 0);
        3: out_stall <= ((phase % period) < (period / 2));
        default: out_stall <= 1'b1;
      endcase
    end
  end

  // Sender: reset, directed samples, then random bursts
  initial begin : sender
    int                       burst;
    int                       sel;
    logic signed [DATA_W-1:0] sample;
    sb             = new();
    items_accepted = 0;
    idle_cycles    = 0;
    in_valid       = 1'b0;
    in_channel     = 1'b0;
    in_sample      = '0;
    in_range_reset = 1'b0;
    rst_n          = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Midpoint, top (saturates) and bottom of the reset range
    send_sample(1'b0, 16'sd0, 1'b0);
    send_sample(1'b0, 16'sd1024, 1'b0);
    send_sample(1'b0, -16'sd1024, 1'b0);
    // Widen channel 1 to the full span, then hit both ends
    send_sample(1'b1, 16'sd32767, 1'b0);
    send_sample(1'b1, -16'sd32768, 1'b0);
    send_sample(1'b1, 16'sd32767, 1'b0);
    // Range reset applies after the flagged sample is normalized
    send_sample(1'b1, 16'sd0, 1'b1);
    send_sample(1'b1, 16'sd0, 1'b0);
    send_sample(1'b0, -16'sd32768, 1'b1);
    send_sample(1'b0, 16'sd1, 1'b0);
    send_sample(1'b0, -16'sd1, 1'b0);
    send_sample(1'b0, 16'sd1023, 1'b0);
    send_sample(1'b0, -16'sd1023, 1'b0);
    send_sample(1'b0, 16'sd1025, 1'b0);
    send_sample(1'b0, -16'sd1025, 1'b0);
    send_sample(1'b0, 16'sd1025, 1'b1);
    send_sample(1'b1, 16'sh5555, 1'b0);
    send_sample(1'b1, 16'shAAAA, 1'b1);
    send_sample(1'b1, 16'shAAAA, 1'b0);
    send_sample(1'b0, 16'sh7FFF, 1'b1);

    // Random bursts with random gaps
    burst = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        if ($urandom_range(0, 3) != 0)
          idle_sender($urandom_range(1, 60));
      end
      burst--;
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1, 2, 3, 4: sample = 16'($urandom_range(0, 2200)) - 16'sd1100;
        5, 6:          sample = 16'($urandom);
        7: begin
          case ($urandom_range(0, 4))
            0:       sample = -16'sd32768;
            1:       sample = 16'sd32767;
            2:       sample = -16'sd1024;
            3:       sample = 16'sd1024;
            default: sample = 16'sd0;
          endcase
        end
        8:       sample = 16'($urandom_range(0, 8192)) - 16'sd4096;
        default: begin
          sample = 16'($urandom_range(1024, 8000));
          if ($urandom_range(0, 1) == 0) sample = -sample;
        end
      endcase
      send_sample(1'($urandom), sample, ($urandom_range(0, 11) == 0));
    end
    idle_sender(1);

    // Drain and let the pipeline settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
